### rtl/plbt_pkg.sv
`timescale 1ns / 1ps
package plbt_pkg;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 31;
    localparam int TIME_W  = 40;
    localparam int MAX_RES = 16;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_FULL     = 3'd3,
        ST_QUERY    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL,
        S_INS,
        S_PUR_RD,
        S_PUR,
        S_UPD_OUT,
        S_Q_RD,
        S_Q_SCAN,
        S_Q_EMIT_RD,
        S_Q_EMIT,
        S_OUT_WAIT
    } state_t;

    typedef struct packed {
        status_t              status;
        logic                 side;
        logic [PRICE_W-1:0]   price;
        logic [QTY_W-1:0]     quantity;
        logic [TIME_W-1:0]    ev_time;
        logic                 empty_res;
        logic                 last;
    } result_t;
endpackage

### rtl/price_level_book_table.sv
`timescale 1ns / 1ps
// channel      | dir | handshake                    | payload
// s_axis       | in  | s_axis_tvalid/s_axis_tready  | tdata: side,price,quantity,event_time,
//              |     |                              |   now_time,level_count; tuser: func
// m_axis       | out | m_axis_tvalid/m_axis_tready  | tdata: status,price,quantity,time;
//              |     |                              |   tuser: out_side,empty_res; tlast
// cfg          | in  | cfg_valid/cfg_ready          | cfg_data: window_ms
// Update: a delete scan over the side's levels and the insert, plus, when the purge
// runs, a walk over every slot, one slot per cycle through the single memory read port.
// An ignored update gives its result without a scan.
// Query: per reported level a read, a scan, a best read and an emit.
// Reset clears the used bits and window_ms to 1000; the level memory is not cleared.
// One item at a time; input waits until the last beat is taken; an output stall holds
// the sequencer.
module price_level_book_table
    import plbt_pkg::*;
#(
    parameter int LEVELS_PER_SIDE = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // side[0], price[32:1], quantity[64:33], event_time[104:65], now_time[144:105],
    // level_count[149:145], zero fill
    input  logic [151:0] s_axis_tdata,
    input  logic         s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], out_price[34:3], out_quantity[65:35], out_time[105:66], zero fill
    output logic [111:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // out_side[0], empty_res[1]
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);
    localparam int LW    = $clog2(LEVELS_PER_SIDE);
    localparam int AW    = LW + 1;
    localparam int SLOTS = 1 << AW;
    localparam int CW    = $clog2(LEVELS_PER_SIDE + 1);
    localparam int LIM   = (LEVELS_PER_SIDE < MAX_RES) ? LEVELS_PER_SIDE : MAX_RES;

    logic [PRICE_W-1:0] mem_price [SLOTS];
    logic [QTY_W-1:0]   mem_qty   [SLOTS];
    logic [TIME_W-1:0]  mem_time  [SLOTS];
    logic [SLOTS-1:0]   used_reg, used_next;

    state_t             state_reg, state_next;
    logic [31:0]        window_reg;
    logic               side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [31:0]        qty_reg;
    logic [TIME_W-1:0]  etime_reg, now_reg;
    logic [CW-1:0]      limit_reg, limit_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW:0]        idx_reg, idx_next;
    logic               free_ok_reg, free_ok_next;
    logic [LW-1:0]      free_reg, free_next;
    logic               best_ok_reg, best_ok_next;
    logic [AW-1:0]      best_reg, best_next;
    logic [PRICE_W-1:0] bestp_reg, bestp_next;
    logic               prev_ok_reg, prev_ok_next;
    logic [PRICE_W-1:0] prev_reg, prev_next;
    result_t            res_reg, res_next;
    logic               out_v_reg, out_v_next;

    logic [AW-1:0]      rd_addr;
    logic [PRICE_W-1:0] rd_price;
    logic [QTY_W-1:0]   rd_qty;
    logic [TIME_W-1:0]  rd_time;
    logic [AW-1:0]      cur_slot;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [TIME_W:0]    oldest;
    logic               purge_on;
    logic [CW-1:0]      want;
    logic               cand;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = {6'd0, res_reg.ev_time, res_reg.quantity, res_reg.price,
                           res_reg.status};
    assign m_axis_tuser = {res_reg.empty_res, res_reg.side};
    assign m_axis_tlast = res_reg.last;

    assign cur_slot = {side_reg, idx_reg[LW-1:0]};
    assign oldest   = {1'b0, now_reg} - {9'd0, window_reg};
    assign purge_on = !oldest[TIME_W];
    assign wr_addr  = {side_reg, free_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_price[wr_addr] <= price_reg;
            mem_qty[wr_addr]   <= qty_reg[QTY_W-1:0];
            mem_time[wr_addr]  <= etime_reg;
        end
        rd_price <= mem_price[rd_addr];
        rd_qty   <= mem_qty[rd_addr];
        rd_time  <= mem_time[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            window_reg <= 32'd1000;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            out_v_reg <= out_v_next;
            if (cfg_valid && cfg_ready)
            begin
                window_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            side_reg  <= s_axis_tdata[0];
            price_reg <= s_axis_tdata[32:1];
            qty_reg   <= s_axis_tdata[64:33];
            etime_reg <= s_axis_tdata[104:65];
            now_reg   <= s_axis_tdata[144:105];
        end
        limit_reg   <= limit_next;
        n_reg       <= n_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        free_ok_reg <= free_ok_next;
        free_reg    <= free_next;
        best_ok_reg <= best_ok_next;
        best_reg    <= best_next;
        bestp_reg   <= bestp_next;
        prev_ok_reg <= prev_ok_next;
        prev_reg    <= prev_next;
        res_reg     <= res_next;
    end

    assign want = (s_axis_tdata[149:145] > 5'(LIM)) ? CW'(LIM) : CW'(s_axis_tdata[149:145]);

    always_comb
    begin
        if (side_reg == 1'b0)
        begin
            cand = used_reg[cur_slot] && (!prev_ok_reg || rd_price < prev_reg)
                && (!best_ok_reg || rd_price > bestp_reg);
        end
        else
        begin
            cand = used_reg[cur_slot] && (!prev_ok_reg || rd_price > prev_reg)
                && (!best_ok_reg || rd_price < bestp_reg);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        out_v_next   = out_v_reg;
        limit_next   = limit_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        free_ok_next = free_ok_reg;
        free_next    = free_reg;
        best_ok_next = best_ok_reg;
        best_next    = best_reg;
        bestp_next   = bestp_reg;
        prev_ok_next = prev_ok_reg;
        prev_next    = prev_reg;
        res_next     = res_reg;
        rd_addr      = cur_slot;
        mem_we       = 1'b0;
        if (out_v_reg && m_axis_tready)
        begin
            out_v_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    idx_next     = '0;
                    limit_next   = want;
                    n_next       = '0;
                    cnt_next     = '0;
                    prev_ok_next = 1'b0;
                    best_ok_next = 1'b0;
                    free_ok_next = 1'b0;
                    if (s_axis_tuser)
                    begin
                        state_next = (want == '0) ? S_Q_EMIT : S_Q_RD;
                    end
                    else if (s_axis_tdata[64])
                    begin
                        res_next = '{ST_IGNORED, s_axis_tdata[0], s_axis_tdata[32:1],
                                     '0, '0, 1'b0, 1'b1};
                        state_next = S_OUT_WAIT;
                    end
                    else
                    begin
                        state_next = S_DEL_RD;
                    end
                end
            end
            S_DEL_RD:
            begin
                state_next = S_DEL;
            end
            S_DEL:
            begin
                if (used_reg[cur_slot] && rd_price == price_reg)
                begin
                    used_next[cur_slot] = 1'b0;
                end
                if ((!used_reg[cur_slot] || rd_price == price_reg) && !free_ok_reg)
                begin
                    free_ok_next = 1'b1;
                    free_next    = idx_reg[LW-1:0];
                end
                if (idx_reg == (AW+1)'(LEVELS_PER_SIDE - 1))
                begin
                    state_next = S_INS;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    rd_addr    = {side_reg, idx_next[LW-1:0]};
                    state_next = S_DEL;
                end
            end
            S_INS:
            begin
                res_next.side      = side_reg;
                res_next.price     = price_reg;
                res_next.quantity  = '0;
                res_next.ev_time   = '0;
                res_next.empty_res = 1'b0;
                res_next.last      = 1'b1;
                if (qty_reg == '0)
                begin
                    res_next.status = ST_REMOVED;
                end
                else if (!free_ok_reg)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    res_next.status   = ST_INSERTED;
                    res_next.quantity = qty_reg[QTY_W-1:0];
                    res_next.ev_time  = etime_reg;
                    mem_we            = 1'b1;
                    used_next[wr_addr] = 1'b1;
                end
                idx_next   = '0;
                rd_addr    = '0;
                state_next = purge_on ? S_PUR_RD : S_OUT_WAIT;
            end
            S_PUR_RD:
            begin
                rd_addr    = idx_reg[AW-1:0];
                state_next = S_PUR;
            end
            S_PUR:
            begin
                if (used_reg[idx_reg[AW-1:0]] && {1'b0, rd_time} < oldest)
                begin
                    used_next[idx_reg[AW-1:0]] = 1'b0;
                end
                idx_next   = idx_reg + 1'b1;
                rd_addr    = idx_next[AW-1:0];
                state_next = (idx_reg == (AW+1)'(SLOTS - 1)) ? S_OUT_WAIT : S_PUR;
            end
            S_Q_RD:
            begin
                state_next = S_Q_SCAN;
            end
            S_Q_SCAN:
            begin
                if (n_reg == '0 && used_reg[cur_slot])
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (cand)
                begin
                    best_ok_next = 1'b1;
                    best_next    = cur_slot;
                    bestp_next   = rd_price;
                end
                if (idx_reg == (AW+1)'(LEVELS_PER_SIDE - 1))
                begin
                    rd_addr    = cand ? cur_slot : best_reg;
                    state_next = S_Q_EMIT_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = {side_reg, idx_next[LW-1:0]};
                end
            end
            S_Q_EMIT_RD:
            begin
                rd_addr    = best_reg;
                state_next = S_Q_EMIT;
            end
            S_Q_EMIT:
            begin
                rd_addr = best_reg;
                if (!out_v_reg || m_axis_tready)
                begin
                    if (!best_ok_reg)
                    begin
                        if (n_reg == '0)
                        begin
                            res_next   = '{ST_QUERY, side_reg, '0, '0, '0, 1'b1, 1'b1};
                            out_v_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        n_next   = n_reg + 1'b1;
                        res_next = '{ST_QUERY, side_reg, rd_price, rd_qty, rd_time, 1'b0,
                                     1'b0};
                        out_v_next   = 1'b1;
                        prev_ok_next = 1'b1;
                        prev_next    = rd_price;
                        best_ok_next = 1'b0;
                        idx_next     = '0;
                        rd_addr      = {side_reg, {LW{1'b0}}};
                        state_next   = S_Q_RD;
                        if (n_next == limit_reg || n_next == cnt_reg)
                        begin
                            res_next.last = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                end
            end
            S_OUT_WAIT:
            begin
                out_v_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !out_v_reg && state_reg == S_IDLE)
        else $error("accept while busy");
    a_full_no_qty: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && res_reg.status == ST_FULL |-> res_reg.quantity == '0)
        else $error("full carries data");
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && res_reg.empty_res |-> res_reg.last)
        else $error("empty not last");
`endif
endmodule
